// ===== hdl/tsf_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and constants for the turn signal flasher
package tsf_pkg;

   localparam int HALF_PERIOD_BITS = 16;
   localparam int DUR_CFG_BITS     = 20;
   localparam int DURATION_BITS_DEFAULT = 20;

   localparam logic [HALF_PERIOD_BITS-1:0] HALF_PERIOD_RESET = 16'd333;
   localparam logic [DUR_CFG_BITS-1:0]     SHORT_DUR_RESET   = 20'd3800;
   localparam logic [DUR_CFG_BITS-1:0]     LONG_DUR_RESET    = 20'd15000;

   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HALF_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHORT_DUR   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_DUR    = 2'd2;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_MODE = 1'b1;

   localparam logic [2:0] MODE_OFF         = 3'd0;
   localparam logic [2:0] MODE_LEFT_SHORT  = 3'd1;
   localparam logic [2:0] MODE_LEFT_LONG   = 3'd2;
   localparam logic [2:0] MODE_RIGHT_SHORT = 3'd3;
   localparam logic [2:0] MODE_RIGHT_LONG  = 3'd4;
   localparam logic [2:0] MODE_HAZARD      = 3'd5;
   localparam logic [2:0] MODE_BAD_LOW     = 3'd6;
   localparam logic [2:0] MODE_BAD_HIGH    = 3'd7;

   typedef struct packed {
      logic en;
      logic tick;
      logic start;
      logic stop;
      logic limited;
   } lamp_cmd_type;

endpackage

// ===== hdl/tsf_csr.sv =====
`timescale 1ns / 1ps
// configuration registers: half period and the two blink durations
module tsf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [tsf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tsf_pkg::DUR_CFG_BITS-1:0]    csr_wdata,
   output logic [tsf_pkg::HALF_PERIOD_BITS-1:0] half_period,
   output logic [tsf_pkg::DUR_CFG_BITS-1:0]    short_dur,
   output logic [tsf_pkg::DUR_CFG_BITS-1:0]    long_dur
);
   import tsf_pkg::*;

   logic [HALF_PERIOD_BITS-1:0] half_period_ff;
   logic [DUR_CFG_BITS-1:0]     short_dur_ff;
   logic [DUR_CFG_BITS-1:0]     long_dur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         short_dur_ff   <= SHORT_DUR_RESET;
         long_dur_ff    <= LONG_DUR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HALF_PERIOD: half_period_ff <= csr_wdata[HALF_PERIOD_BITS-1:0];
            CSR_SHORT_DUR:   short_dur_ff   <= csr_wdata;
            CSR_LONG_DUR:    long_dur_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign half_period = half_period_ff;
   assign short_dur   = short_dur_ff;
   assign long_dur    = long_dur_ff;
endmodule

// ===== hdl/tsf_lamp.sv =====
`timescale 1ns / 1ps
// one lamp: blink enable, level, toggle counter and duration countdown
module tsf_lamp #(
   parameter int DURATION_BITS = tsf_pkg::DURATION_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tsf_pkg::lamp_cmd_type                cmd,
   input  logic [DURATION_BITS-1:0]             duration,
   input  logic [tsf_pkg::HALF_PERIOD_BITS-1:0] half_period,
   output logic                                 level_next
);
   import tsf_pkg::*;

   logic                        blinking_ff, blinking_in;
   logic                        level_ff, level_in;
   logic                        limited_ff, limited_in;
   logic [HALF_PERIOD_BITS-1:0] count_ff, count_in, count_inc;
   logic [DURATION_BITS-1:0]    left_ff, left_in;

   assign count_inc = HALF_PERIOD_BITS'(count_ff + 1'b1);

   always_comb begin
      blinking_in = blinking_ff;
      level_in    = level_ff;
      limited_in  = limited_ff;
      count_in    = count_ff;
      left_in     = left_ff;
      if (cmd.en) begin
         if (cmd.start) begin
            blinking_in = 1'b1;
            level_in    = 1'b1;
            count_in    = '0;
            limited_in  = cmd.limited;
            left_in     = cmd.limited ? duration : '0;
         end else if (cmd.stop) begin
            blinking_in = 1'b0;
            level_in    = 1'b0;
            count_in    = '0;
            limited_in  = 1'b0;
            left_in     = '0;
         end else if (cmd.tick && blinking_ff) begin
            if (limited_ff && (left_ff <= DURATION_BITS'(1))) begin
               // duration over: wins over any toggle
               blinking_in = 1'b0;
               level_in    = 1'b0;
               count_in    = '0;
               limited_in  = 1'b0;
               left_in     = '0;
            end else begin
               if (limited_ff) begin
                  left_in = DURATION_BITS'(left_ff - 1'b1);
               end
               if (count_inc >= half_period) begin
                  level_in = ~level_ff;
                  count_in = '0;
               end else begin
                  count_in = count_inc;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blinking_ff <= 1'b0;
         level_ff    <= 1'b0;
         limited_ff  <= 1'b0;
         count_ff    <= '0;
         left_ff     <= '0;
      end else begin
         blinking_ff <= blinking_in;
         level_ff    <= level_in;
         limited_ff  <= limited_in;
         count_ff    <= count_in;
         left_ff     <= left_in;
      end
   end

   assign level_next = level_in;
endmodule

// ===== hdl/turn_signal_flasher_unit.sv =====
`timescale 1ns / 1ps
// response path: an accepted request is held in the request register, then
// its response in the response register
// throughput: one request per cycle when the response is not stalled; lamp and mode state update in one pass
// reset: synchronous, active high; lamps dark, mode off, registers to defaults
// top level of the turn signal and hazard flasher
module turn_signal_flasher_unit #(
   parameter int DURATION_BITS = tsf_pkg::DURATION_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_opcode,
   input  logic [2:0]                         req_mode_code,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_left_lamp,
   output logic                               rsp_right_lamp,
   output logic [2:0]                         rsp_mode_now,
   output logic                               rsp_rejected,
   input  logic                               csr_we,
   input  logic [tsf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tsf_pkg::DUR_CFG_BITS-1:0]   csr_wdata
);
   import tsf_pkg::*;

   logic [HALF_PERIOD_BITS-1:0] half_period;
   logic [DUR_CFG_BITS-1:0]     short_dur, long_dur;
   logic [DUR_CFG_BITS+DURATION_BITS-1:0] short_ext, long_ext;
   logic [DURATION_BITS-1:0]    short_mask, long_mask;

   logic       req_valid_ff;
   logic       req_op_ff;
   logic [2:0] req_code_ff;
   logic       advance;

   logic       rsp_valid_ff;
   logic       rsp_left_ff, rsp_right_ff, rsp_rejected_ff;
   logic [2:0] rsp_mode_ff;

   logic [2:0] stored_mode_ff, stored_mode_in;
   logic [2:0] prev_mode_ff, prev_mode_in;
   logic       hazard_ff, hazard_in;

   logic         is_cmd, bad_code, hazard_next;
   logic         left_level, right_level;
   lamp_cmd_type left_cmd, right_cmd;
   logic [DURATION_BITS-1:0] left_dur, right_dur;

   tsf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .half_period (half_period),
      .short_dur   (short_dur),
      .long_dur    (long_dur)
   );

   assign short_ext  = {{DURATION_BITS{1'b0}}, short_dur};
   assign long_ext   = {{DURATION_BITS{1'b0}}, long_dur};
   assign short_mask = short_ext[DURATION_BITS-1:0];
   assign long_mask  = long_ext[DURATION_BITS-1:0];

   // request register and response register handshake
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_op_ff   <= req_opcode;
         req_code_ff <= req_mode_code;
      end
   end

   // mode decode
   assign is_cmd      = (req_op_ff == OP_MODE);
   assign bad_code    = (req_code_ff == MODE_BAD_LOW) || (req_code_ff == MODE_BAD_HIGH);
   assign hazard_next = (prev_mode_ff == MODE_HAZARD) ? ~hazard_ff : 1'b1;

   always_comb begin
      left_cmd         = '0;
      right_cmd        = '0;
      left_cmd.en      = advance;
      right_cmd.en     = advance;
      left_cmd.tick    = !is_cmd;
      right_cmd.tick   = !is_cmd;
      left_dur         = short_mask;
      right_dur        = short_mask;
      stored_mode_in   = stored_mode_ff;
      prev_mode_in     = prev_mode_ff;
      hazard_in        = hazard_ff;
      if (is_cmd) begin
         stored_mode_in = req_code_ff;
         if (!bad_code) begin
            prev_mode_in = req_code_ff;
         end
         unique case (req_code_ff) inside
            MODE_OFF: begin
               left_cmd.stop  = 1'b1;
               right_cmd.stop = 1'b1;
            end
            MODE_LEFT_SHORT, MODE_LEFT_LONG: begin
               left_cmd.start   = 1'b1;
               left_cmd.limited = 1'b1;
               left_dur         = (req_code_ff == MODE_LEFT_LONG) ? long_mask : short_mask;
               right_cmd.stop   = 1'b1;
            end
            MODE_RIGHT_SHORT, MODE_RIGHT_LONG: begin
               right_cmd.start   = 1'b1;
               right_cmd.limited = 1'b1;
               right_dur         = (req_code_ff == MODE_RIGHT_LONG) ? long_mask : short_mask;
               left_cmd.stop     = 1'b1;
            end
            MODE_HAZARD: begin
               hazard_in       = hazard_next;
               left_cmd.start  = hazard_next;
               right_cmd.start = hazard_next;
               left_cmd.stop   = !hazard_next;
               right_cmd.stop  = !hazard_next;
            end
            default: ;
         endcase
      end
   end

   tsf_lamp #(.DURATION_BITS(DURATION_BITS)) u_lamp_left (
      .clock       (clock),
      .reset       (reset),
      .cmd         (left_cmd),
      .duration    (left_dur),
      .half_period (half_period),
      .level_next  (left_level)
   );

   tsf_lamp #(.DURATION_BITS(DURATION_BITS)) u_lamp_right (
      .clock       (clock),
      .reset       (reset),
      .cmd         (right_cmd),
      .duration    (right_dur),
      .half_period (half_period),
      .level_next  (right_level)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_mode_ff <= MODE_OFF;
         prev_mode_ff   <= MODE_OFF;
         hazard_ff      <= 1'b0;
      end else if (advance) begin
         stored_mode_ff <= stored_mode_in;
         prev_mode_ff   <= prev_mode_in;
         hazard_ff      <= hazard_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_left_ff     <= left_level;
         rsp_right_ff    <= right_level;
         rsp_mode_ff     <= stored_mode_in;
         rsp_rejected_ff <= is_cmd && bad_code;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_left_lamp  = rsp_left_ff;
   assign rsp_right_lamp = rsp_right_ff;
   assign rsp_mode_now   = rsp_mode_ff;
   assign rsp_rejected   = rsp_rejected_ff;
endmodule

// ===== hdl/tsf_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the flasher and their binding to the top level
module tsf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_left_lamp,
   input logic       rsp_right_lamp,
   input logic [2:0] rsp_mode_now,
   input logic       rsp_rejected
);
   import tsf_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_lamp)
         && $stable(rsp_right_lamp) && $stable(rsp_mode_now) && $stable(rsp_rejected))
      else $error("stalled response changed");

   a_reject_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |->
         (rsp_mode_now == MODE_BAD_LOW) || (rsp_mode_now == MODE_BAD_HIGH))
      else $error("rejected with a valid mode code");

   a_off_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode_now == MODE_OFF) |-> !rsp_left_lamp && !rsp_right_lamp)
      else $error("lamp lit in off mode");

   a_left_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_mode_now == MODE_LEFT_SHORT) || (rsp_mode_now == MODE_LEFT_LONG))
         |-> !rsp_right_lamp)
      else $error("right lamp lit in a left mode");
endmodule

bind turn_signal_flasher_unit tsf_checker u_tsf_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_left_lamp  (rsp_left_lamp),
   .rsp_right_lamp (rsp_right_lamp),
   .rsp_mode_now   (rsp_mode_now),
   .rsp_rejected   (rsp_rejected)
);
